// ===== rtl/plt_pkg.sv =====
package plt_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MIN_DIST = 3'd0;
    localparam logic [2:0] REG_MAX_DIST = 3'd1;
    localparam logic [2:0] REG_FALLOFF  = 3'd2;
    localparam logic [2:0] REG_SCALER   = 3'd3;
    localparam logic [2:0] REG_BLEND    = 3'd4;

    localparam logic [30:0] MAX_DIST_RST = 31'd655360;
    localparam logic [30:0] SCALER_RST   = 31'd65536;
    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [47:0] DEV_MAX      = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] ARC_MAX      = 32'hFFFF_FFFF;

    // Step counts of the shared iterative unit
    localparam logic [6:0] SQRT_STEPS = 7'd32;
    localparam logic [6:0] DEV_STEPS  = 7'd48;
    localparam logic [6:0] FULL_STEPS = 7'd64;

    typedef struct packed {
        logic [30:0] min_dist;
        logic [30:0] max_dist;
        logic [30:0] falloff;
        logic [30:0] scaler;
        logic [16:0] blend;
    } cfg_t;

    typedef struct packed {
        logic [32:0] mul_a;
        logic [31:0] mul_b;
        logic        ld;
        logic        sqrt;
        logic [63:0] rem_init;
        logic [63:0] quo_init;
        logic [63:0] divisor;
        logic [6:0]  steps;
    } alu_cmd_t;

    typedef struct packed {
        logic [64:0] prod;
        logic [63:0] quo;
        logic [31:0] root;
        logic        busy;
    } alu_res_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SEG, ST_SQY, ST_SQLD, ST_SQW, ST_ARC, ST_NUM, ST_DEN,
        ST_DCHK, ST_DIVW, ST_ACC, ST_STORE, ST_FIN, ST_FDIV, ST_FDIVW,
        ST_BL1, ST_BL2, ST_BL3, ST_WA, ST_WB, ST_WC, ST_RX0, ST_RX1, ST_RX2,
        ST_FRAC, ST_FRACW, ST_IX, ST_IY, ST_IYW, ST_OUT
    } state_t;

endpackage

// ===== rtl/plt_ram.sv =====
module plt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/plt_cfg.sv =====
module plt_cfg
    import plt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [2:0]  idx;
    logic        wr;

    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_MIN_DIST: cfg_next.min_dist = pwdata[30:0];
                REG_MAX_DIST: cfg_next.max_dist = pwdata[30:0];
                REG_FALLOFF:  cfg_next.falloff  = pwdata[30:0];
                REG_SCALER:   cfg_next.scaler   = pwdata[30:0];
                REG_BLEND:    cfg_next.blend    = pwdata[16:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_dist <= '0;
            cfg_reg.max_dist <= MAX_DIST_RST;
            cfg_reg.falloff  <= '0;
            cfg_reg.scaler   <= SCALER_RST;
            cfg_reg.blend    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_MIN_DIST: prdata = {1'b0, cfg_reg.min_dist};
            REG_MAX_DIST: prdata = {1'b0, cfg_reg.max_dist};
            REG_FALLOFF:  prdata = {1'b0, cfg_reg.falloff};
            REG_SCALER:   prdata = {1'b0, cfg_reg.scaler};
            REG_BLEND:    prdata = {15'b0, cfg_reg.blend};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/plt_alu.sv =====
module plt_alu
    import plt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_cmd_t cmd,
    output alu_res_t res
);

    logic [64:0] prod_reg;
    logic [63:0] rem_reg;
    logic [63:0] rem_next;
    logic [63:0] quo_reg;
    logic [63:0] quo_next;
    logic [63:0] dvs_reg;
    logic [31:0] root_reg;
    logic [31:0] root_next;
    logic        sqrt_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic [64:0] trial;
    logic [64:0] opb;
    logic [65:0] diff;
    logic        ge;

    // shared compare and subtract: restoring division or square root step
    assign trial = sqrt_reg ? {rem_reg[62:0], quo_reg[63:62]} : {rem_reg, quo_reg[63]};
    assign opb   = sqrt_reg ? {31'b0, root_reg, 2'b01} : {1'b0, dvs_reg};
    assign diff  = {1'b0, trial} - {1'b0, opb};
    assign ge    = ~diff[65];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (cmd.ld)
        begin
            rem_next  = cmd.rem_init;
            quo_next  = cmd.quo_init;
            root_next = '0;
            cnt_next  = cmd.steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[63:0] : trial[63:0];
            cnt_next = cnt_reg - 7'd1;
            if (sqrt_reg)
            begin
                quo_next  = {quo_reg[61:0], 2'b00};
                root_next = {root_reg[30:0], ge};
            end
            else
            begin
                quo_next = {quo_reg[62:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // multiplier with registered product, iteration registers
    always_ff @(posedge clk)
    begin
        prod_reg <= cmd.mul_a * cmd.mul_b;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        root_reg <= root_next;
        if (cmd.ld)
        begin
            dvs_reg  <= cmd.divisor;
            sqrt_reg <= cmd.sqrt;
        end
    end

    assign res.prod = prod_reg;
    assign res.quo  = quo_reg;
    assign res.root = root_reg;
    assign res.busy = (cnt_reg != '0);

endmodule

// ===== rtl/path_lookahead_target_point_unit.sv =====
// Lookahead target point on a path, Q16.16 fixed point.
// Path points enter on point_x/point_y/last_point under point_valid and
// point_stall; each point that fits is stored, and each after the first
// adds to the arc length and the deviation sum. A point with last_point
// set produces one item on target_x/target_y/lookahead_distance and
// points_dropped under target_valid and target_stall. Configuration goes
// through the APB port (index * 4). Work runs on one shared multiplier and
// one shared 65-bit subtract unit that runs division and square root one bit
// per cycle: the first point of a path is only stored; a later point takes a
// segment square root and a deviation divide; the last point adds a
// distance divide and blend, a walk over the stored arc lengths, and the
// interpolation divide and output.
// The block takes one item at a time; point_stall is high while it works.
// The result sits in an output register; while target_stall holds it the
// block may keep loading points, and only waits before writing the next
// result. Reset clears path state, flags and the previous distance to zero;
// the point stores need no clearing.
module path_lookahead_target_point_unit
    import plt_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_stall,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic               last_point,
    output logic               target_valid,
    input  logic               target_stall,
    output logic signed [31:0] target_x,
    output logic signed [31:0] target_y,
    output logic [30:0]        lookahead_distance,
    output logic               points_dropped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    cfg_t     cfg;
    alu_cmd_t alu_cmd;
    alu_res_t alu_res;

    state_t      state_reg, state_next;
    logic [31:0] px_reg, px_next, py_reg, py_next;
    logic        last_reg, last_next;
    logic [31:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] arc_reg, arc_next;
    logic [47:0] dev_reg, dev_next;
    logic        ovf_reg, ovf_next;
    logic [30:0] prevd_reg, prevd_next;
    logic [62:0] num_reg, num_next;
    logic [47:0] term_reg, term_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] seg_reg, seg_next;
    logic [30:0] td_reg, td_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0] ap_reg, ap_next, ai_reg, ai_next;
    logic [31:0] x0_reg, x0_next, y0_reg, y0_next, x1_reg, x1_next, y1_reg, y1_next;
    logic [30:0] frac_reg, frac_next;
    logic [31:0] tx_reg, tx_next, ty_reg, ty_next;
    logic        tvalid_reg, tvalid_next;
    logic [31:0] otx_reg, otx_next, oty_reg, oty_next;
    logic [30:0] odist_reg, odist_next;
    logic        odrop_reg, odrop_next;

    logic          we;
    logic [AW-1:0] raddr;
    logic [31:0]   xr, yr, ar;

    // datapath helpers
    logic [30:0] mx;
    logic [32:0] dx, dy, ax, ay;
    logic [31:0] apy;
    logic [32:0] arc_sum;
    logic [48:0] dev_sum;
    logic [63:0] den;
    logic [30:0] q_clamp;
    logic [16:0] w_sat, w_inv;
    logic [63:0] blend_sum;
    logic [31:0] seg_w, td_ext, t_raw, t_cl;
    logic [32:0] ddx, ddy, adx, ady;
    logic [63:0] off_full;
    logic [31:0] off;
    logic [31:0] lerp_x, lerp_y;

    assign mx      = (cfg.max_dist < cfg.min_dist) ? cfg.min_dist : cfg.max_dist;
    assign dx      = {px_reg[31], px_reg} - {prev_x_reg[31], prev_x_reg};
    assign dy      = {py_reg[31], py_reg} - {prev_y_reg[31], prev_y_reg};
    assign ax      = dx[32] ? (~dx + 33'd1) : dx;
    assign ay      = dy[32] ? (~dy + 33'd1) : dy;
    assign apy     = py_reg[31] ? (~py_reg + 32'd1) : py_reg;
    assign arc_sum = {1'b0, arc_reg} + {1'b0, seg_reg};
    assign dev_sum = {1'b0, dev_reg} + {1'b0, term_reg};
    assign den     = alu_res.prod[63:0];
    assign w_sat   = (cfg.blend > ONE_Q16) ? ONE_Q16 : cfg.blend;
    assign w_inv   = ONE_Q16 - w_sat;
    assign blend_sum = acc_reg + alu_res.prod[63:0] + 64'd32768;
    assign seg_w   = ai_reg - ap_reg;
    assign td_ext  = {1'b0, td_reg};
    assign t_raw   = (td_ext > ap_reg) ? (td_ext - ap_reg) : 32'd0;
    assign t_cl    = (t_raw > seg_w) ? seg_w : t_raw;
    assign ddx     = {x1_reg[31], x1_reg} - {x0_reg[31], x0_reg};
    assign ddy     = {y1_reg[31], y1_reg} - {y0_reg[31], y0_reg};
    assign adx     = ddx[32] ? (~ddx + 33'd1) : ddx;
    assign ady     = ddy[32] ? (~ddy + 33'd1) : ddy;
    assign off_full = alu_res.prod[63:0] + 64'h2000_0000;
    assign off     = off_full[61:30];
    assign lerp_x  = ddx[32] ? (x0_reg - off) : (x0_reg + off);
    assign lerp_y  = ddy[32] ? (y0_reg - off) : (y0_reg + off);

    // clamp of the raw distance to [min, effective max]
    always_comb
    begin
        if (alu_res.quo < {33'b0, cfg.min_dist})
        begin
            q_clamp = cfg.min_dist;
        end
        else if (alu_res.quo > {33'b0, mx})
        begin
            q_clamp = mx;
        end
        else
        begin
            q_clamp = alu_res.quo[30:0];
        end
    end

    plt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plt_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .res   (alu_res)
    );

    plt_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xmem (
        .clk (clk), .we (we), .waddr (count_reg[AW-1:0]), .wdata (px_reg),
        .raddr (raddr), .rdata (xr)
    );

    plt_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ymem (
        .clk (clk), .we (we), .waddr (count_reg[AW-1:0]), .wdata (py_reg),
        .raddr (raddr), .rdata (yr)
    );

    plt_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_amem (
        .clk (clk), .we (we), .waddr (count_reg[AW-1:0]), .wdata (arc_reg),
        .raddr (raddr), .rdata (ar)
    );

    assign point_stall        = (state_reg != ST_IDLE);
    assign target_valid       = tvalid_reg;
    assign target_x           = otx_reg;
    assign target_y           = oty_reg;
    assign lookahead_distance = odist_reg;
    assign points_dropped     = odrop_reg;

    // sequencer: next state, datapath controls
    always_comb
    begin
        state_next  = state_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        last_next   = last_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        count_next  = count_reg;
        arc_next    = arc_reg;
        dev_next    = dev_reg;
        ovf_next    = ovf_reg;
        prevd_next  = prevd_reg;
        num_next    = num_reg;
        term_next   = term_reg;
        acc_next    = acc_reg;
        seg_next    = seg_reg;
        td_next     = td_reg;
        idx_next    = idx_reg;
        ap_next     = ap_reg;
        ai_next     = ai_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        x1_next     = x1_reg;
        y1_next     = y1_reg;
        frac_next   = frac_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        otx_next    = otx_reg;
        oty_next    = oty_reg;
        odist_next  = odist_reg;
        odrop_next  = odrop_reg;
        tvalid_next = tvalid_reg & target_stall;
        we          = 1'b0;
        raddr       = idx_reg;
        alu_cmd     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (point_valid)
                begin
                    px_next   = point_x;
                    py_next   = point_y;
                    last_next = last_point;
                    if (count_reg < CW'(MAX_POINTS))
                    begin
                        state_next = (count_reg != '0) ? ST_SEG : ST_STORE;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        state_next = last_point ? ST_FIN : ST_IDLE;
                    end
                end
            end
            // segment length: saturate or square and root
            ST_SEG:
            begin
                if (ax[32:31] != 2'b00 || ay[32:31] != 2'b00)
                begin
                    seg_next   = ARC_MAX;
                    state_next = ST_ARC;
                end
                else
                begin
                    alu_cmd.mul_a = ax;
                    alu_cmd.mul_b = ax[31:0];
                    state_next    = ST_SQY;
                end
            end
            ST_SQY:
            begin
                acc_next      = alu_res.prod[63:0];
                alu_cmd.mul_a = ay;
                alu_cmd.mul_b = ay[31:0];
                state_next    = ST_SQLD;
            end
            ST_SQLD:
            begin
                alu_cmd.ld       = 1'b1;
                alu_cmd.sqrt     = 1'b1;
                alu_cmd.quo_init = acc_reg + alu_res.prod[63:0];
                alu_cmd.steps    = SQRT_STEPS;
                state_next       = ST_SQW;
            end
            ST_SQW:
            begin
                if (!alu_res.busy)
                begin
                    seg_next   = alu_res.root;
                    state_next = ST_ARC;
                end
            end
            ST_ARC:
            begin
                arc_next   = arc_sum[32] ? ARC_MAX : arc_sum[31:0];
                state_next = ST_NUM;
            end
            // deviation term |y| * max * 2^16 / (arc * (1 + falloff))
            ST_NUM:
            begin
                if (arc_reg == '0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    alu_cmd.mul_a = {1'b0, apy};
                    alu_cmd.mul_b = {1'b0, mx};
                    state_next    = ST_DEN;
                end
            end
            ST_DEN:
            begin
                num_next      = alu_res.prod[62:0];
                alu_cmd.mul_a = {1'b0, arc_reg};
                alu_cmd.mul_b = {15'b0, ONE_Q16} + {1'b0, cfg.falloff};
                state_next    = ST_DCHK;
            end
            ST_DCHK:
            begin
                if ({33'b0, num_reg[62:32]} >= den)
                begin
                    term_next  = DEV_MAX;
                    state_next = ST_ACC;
                end
                else
                begin
                    alu_cmd.ld       = 1'b1;
                    alu_cmd.rem_init = {33'b0, num_reg[62:32]};
                    alu_cmd.quo_init = {num_reg[31:0], 32'b0};
                    alu_cmd.divisor  = den;
                    alu_cmd.steps    = DEV_STEPS;
                    state_next       = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (!alu_res.busy)
                begin
                    term_next  = alu_res.quo[47:0];
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                dev_next   = dev_sum[48] ? DEV_MAX : dev_sum[47:0];
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                we          = 1'b1;
                prev_x_next = px_reg;
                prev_y_next = py_reg;
                count_next  = count_reg + CW'(1);
                state_next  = last_reg ? ST_FIN : ST_IDLE;
            end
            // raw distance max * scaler / deviation
            ST_FIN:
            begin
                if (dev_reg == '0)
                begin
                    td_next    = mx;
                    state_next = ST_BL1;
                end
                else
                begin
                    alu_cmd.mul_a = {2'b0, mx};
                    alu_cmd.mul_b = {1'b0, cfg.scaler};
                    state_next    = ST_FDIV;
                end
            end
            ST_FDIV:
            begin
                alu_cmd.ld       = 1'b1;
                alu_cmd.quo_init = alu_res.prod[63:0];
                alu_cmd.divisor  = {16'b0, dev_reg};
                alu_cmd.steps    = FULL_STEPS;
                state_next       = ST_FDIVW;
            end
            ST_FDIVW:
            begin
                if (!alu_res.busy)
                begin
                    td_next    = q_clamp;
                    state_next = ST_BL1;
                end
            end
            // blend with the previous distance
            ST_BL1:
            begin
                alu_cmd.mul_a = {16'b0, w_inv};
                alu_cmd.mul_b = {1'b0, td_reg};
                state_next    = ST_BL2;
            end
            ST_BL2:
            begin
                acc_next      = alu_res.prod[63:0];
                alu_cmd.mul_a = {16'b0, w_sat};
                alu_cmd.mul_b = {1'b0, prevd_reg};
                state_next    = ST_BL3;
            end
            ST_BL3:
            begin
                td_next    = blend_sum[46:16];
                prevd_next = blend_sum[46:16];
                if (count_reg <= CW'(1))
                begin
                    tx_next    = prev_x_reg;
                    ty_next    = prev_y_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_WA;
                end
            end
            // walk stored arc lengths, one entry a cycle
            ST_WA:
            begin
                raddr      = '0;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                ap_next    = ar;
                idx_next   = AW'(1);
                raddr      = AW'(1);
                state_next = ST_WC;
            end
            ST_WC:
            begin
                if (ar >= td_ext)
                begin
                    ai_next    = ar;
                    state_next = ST_RX0;
                end
                else if (CW'(idx_reg) + CW'(1) == count_reg)
                begin
                    tx_next    = prev_x_reg;
                    ty_next    = prev_y_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    ap_next  = ar;
                    idx_next = idx_reg + AW'(1);
                    raddr    = idx_reg + AW'(1);
                end
            end
            ST_RX0:
            begin
                raddr      = idx_reg - AW'(1);
                state_next = ST_RX1;
            end
            ST_RX1:
            begin
                x0_next    = xr;
                y0_next    = yr;
                raddr      = idx_reg;
                state_next = ST_RX2;
            end
            ST_RX2:
            begin
                x1_next    = xr;
                y1_next    = yr;
                state_next = ST_FRAC;
            end
            // interpolation fraction (t << 30) / segment
            ST_FRAC:
            begin
                if (seg_w == '0)
                begin
                    tx_next    = x1_reg;
                    ty_next    = y1_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    alu_cmd.ld       = 1'b1;
                    alu_cmd.quo_init = {2'b0, t_cl, 30'b0};
                    alu_cmd.divisor  = {32'b0, seg_w};
                    alu_cmd.steps    = FULL_STEPS;
                    state_next       = ST_FRACW;
                end
            end
            ST_FRACW:
            begin
                if (!alu_res.busy)
                begin
                    frac_next  = alu_res.quo[30:0];
                    state_next = ST_IX;
                end
            end
            ST_IX:
            begin
                alu_cmd.mul_a = adx;
                alu_cmd.mul_b = {1'b0, frac_reg};
                state_next    = ST_IY;
            end
            ST_IY:
            begin
                tx_next       = lerp_x;
                alu_cmd.mul_a = ady;
                alu_cmd.mul_b = {1'b0, frac_reg};
                state_next    = ST_IYW;
            end
            ST_IYW:
            begin
                ty_next    = lerp_y;
                state_next = ST_OUT;
            end
            // hand the item to the output register, clear path state
            ST_OUT:
            begin
                if (!tvalid_reg || !target_stall)
                begin
                    tvalid_next = 1'b1;
                    otx_next    = tx_reg;
                    oty_next    = ty_reg;
                    odist_next  = td_reg;
                    odrop_next  = ovf_reg;
                    count_next  = '0;
                    arc_next    = '0;
                    dev_next    = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            arc_reg    <= '0;
            dev_reg    <= '0;
            ovf_reg    <= 1'b0;
            prevd_reg  <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            arc_reg    <= arc_next;
            dev_reg    <= dev_next;
            ovf_reg    <= ovf_next;
            prevd_reg  <= prevd_next;
            tvalid_reg <= tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        num_reg    <= num_next;
        term_reg   <= term_next;
        acc_reg    <= acc_next;
        seg_reg    <= seg_next;
        td_reg     <= td_next;
        idx_reg    <= idx_next;
        ap_reg     <= ap_next;
        ai_reg     <= ai_next;
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        frac_reg   <= frac_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        otx_reg    <= otx_next;
        oty_reg    <= oty_next;
        odist_reg  <= odist_next;
        odrop_reg  <= odrop_next;
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == CW'(MAX_POINTS))
        else $error("drop flag set with store not full");

    a_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_cmd.ld |-> !alu_res.busy)
        else $error("shared unit loaded while busy");

    a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && state_next == ST_IDLE)
        |=> (count_reg == '0 && dev_reg == '0 && tvalid_reg))
        else $error("path state not cleared on result");

endmodule
